// ===== rtl/ple_pkg.sv =====
// shared types and constants for the positional list engine
// used by the cell chain, the top level and the port checker
package ple_pkg;

  localparam int CAPACITY_DEF = 128;
  localparam int POS_W = 11;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_LOCATE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  count;
    logic              shift;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [DATA_W-1:0] data;
    logic [POS_W-1:0]  found;
  } pkt_t;

endpackage

// ===== rtl/ple_cell.sv =====
// one list entry of the chain, plus the stage of the scan packet that
// walks past it; depends on ple_pkg
module ple_cell import ple_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic [DATA_W-1:0] left_val,
  input  logic [DATA_W-1:0] right_val,
  input  pkt_t              pkt_in,
  output pkt_t              pkt_out,
  output logic [DATA_W-1:0] entry_out
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX + 1);

  logic [DATA_W-1:0] entry_r, entry_nxt;
  pkt_t              pkt_r, pkt_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.shift) begin
      if (cmd.op == OP_INSERT) begin
        if (MY_POS == cmd.pos) begin
          entry_nxt = cmd.value;
        end else if (MY_POS > cmd.pos) begin
          entry_nxt = left_val;
        end
      end else if (cmd.op == OP_DELETE) begin
        if (MY_POS >= cmd.pos) begin
          entry_nxt = right_val;
        end
      end
    end
  end

  always_comb begin
    pkt_nxt = pkt_in;
    if (pkt_in.valid) begin
      if ((cmd.op inside {OP_DELETE, OP_GET}) && MY_POS == cmd.pos) begin
        pkt_nxt.data = entry_r;
      end
      if (cmd.op == OP_LOCATE && !pkt_in.hit && MY_POS <= cmd.count &&
          entry_r == cmd.value) begin
        pkt_nxt.hit   = 1'b1;
        pkt_nxt.found = MY_POS;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      pkt_r.valid <= 1'b0;
    end else begin
      pkt_r.valid <= pkt_nxt.valid;
    end
    pkt_r.hit   <= pkt_nxt.hit;
    pkt_r.data  <= pkt_nxt.data;
    pkt_r.found <= pkt_nxt.found;
  end

  assign pkt_out   = pkt_r;
  assign entry_out = entry_r;

endmodule

// ===== rtl/positional_list_engine_core.sv =====
// positional list engine top level: request handling, result register
// and the chain of ple_cell entries; depends on ple_pkg and ple_cell
//
// usage:
//   in_* channel carries one request (op, position, value) per transfer.
//   out_* channel returns one result per request (status, data_out,
//   found_position, length).
//   a request is taken only when the block is idle; a scan packet then
//   walks the cell chain one cell per cycle to read, delete-capture or
//   locate, and an insert or delete shifts all cells at once at the
//   end. the request is registered, its scan packet passes every cell
//   of the chain, and the result is registered as the packet leaves the
//   last cell. the next request is taken the cycle after the result
//   transfer, so requests are handled one at a time.
//   reset empties the list (length 0); entry contents are not cleared
//   and are never read before being written.
//   while the receiver stalls the result holds in its output register
//   and no new request is taken.
module positional_list_engine_core import ple_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // op[1:0], position[9:2], value[41:10], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // status[1:0], data_out[33:2], found_position[41:34],
                                  // length[49:42], zero pad
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_t;

  localparam logic [POS_W-1:0] CAP = POS_W'(CAPACITY);

  state_t            state_r;
  cmd_t              cmd;
  op_t               op_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] value_r;
  logic [POS_W-1:0]  count_r;
  status_t           status_r;
  logic              start_r;
  logic              shift_r;
  status_t           res_status_r;
  logic [DATA_W-1:0] res_data_r;
  logic [7:0]        res_found_r;
  logic [7:0]        res_len_r;

  logic [DATA_W-1:0] ent [CAPACITY];
  pkt_t              pkt [CAPACITY+1];

  op_t               in_op;
  logic [POS_W-1:0]  in_pos;
  status_t           chk_status;
  logic              accept;
  pkt_t              last_pkt;
  status_t           fin_status;

  assign in_op  = op_t'(in_tdata[1:0]);
  assign in_pos = POS_W'(in_tdata[9:2]);
  assign accept = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    chk_status = ST_DONE;
    case (in_op)
      OP_INSERT: begin
        if (in_pos == '0 || in_pos > count_r + POS_W'(1)) begin
          chk_status = ST_RANGE;
        end else if (count_r >= CAP) begin
          chk_status = ST_FULL;
        end
      end
      OP_DELETE, OP_GET: begin
        if (in_pos == '0 || in_pos > count_r) begin
          chk_status = ST_RANGE;
        end
      end
      default: chk_status = ST_DONE;
    endcase
  end

  assign cmd.op    = op_r;
  assign cmd.pos   = pos_r;
  assign cmd.value = value_r;
  assign cmd.count = count_r;
  assign cmd.shift = shift_r;

  assign pkt[0].valid = start_r;
  assign pkt[0].hit   = 1'b0;
  assign pkt[0].data  = '0;
  assign pkt[0].found = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] lv, rv;
    if (i == 0) begin : g_first
      assign lv = value_r;
    end else begin : g_mid
      assign lv = ent[i-1];
    end
    if (i == CAPACITY-1) begin : g_last
      assign rv = ent[i];
    end else begin : g_inner
      assign rv = ent[i+1];
    end
    ple_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_val  (lv),
      .right_val (rv),
      .pkt_in    (pkt[i]),
      .pkt_out   (pkt[i+1]),
      .entry_out (ent[i])
    );
  end

  assign last_pkt = pkt[CAPACITY];

  always_comb begin
    fin_status = status_r;
    if (status_r == ST_DONE && op_r == OP_LOCATE && !last_pkt.hit) begin
      fin_status = ST_MISSING;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      start_r <= 1'b0;
      shift_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      shift_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r     <= in_op;
            pos_r    <= in_pos;
            value_r  <= in_tdata[41:10];
            status_r <= chk_status;
            start_r  <= 1'b1;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (last_pkt.valid) begin
            res_status_r <= fin_status;
            res_data_r   <= '0;
            res_found_r  <= '0;
            res_len_r    <= count_r[7:0];
            if (status_r == ST_DONE) begin
              case (op_r)
                OP_INSERT: begin
                  shift_r   <= 1'b1;
                  count_r   <= count_r + POS_W'(1);
                  res_len_r <= 8'(count_r + POS_W'(1));
                end
                OP_DELETE: begin
                  shift_r    <= 1'b1;
                  count_r    <= count_r - POS_W'(1);
                  res_len_r  <= 8'(count_r - POS_W'(1));
                  res_data_r <= last_pkt.data;
                end
                OP_GET: res_data_r <= last_pkt.data;
                default: res_found_r <= last_pkt.found[7:0];
              endcase
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {6'd0, res_len_r, res_found_r, res_data_r, res_status_r};

endmodule

// ===== rtl/ple_port_check.sv =====
// port-level checks for the positional list engine, attached by bind
// depends on ple_pkg and positional_list_engine_core
module ple_port_check import ple_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("request taken while a result is pending");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid && !in_tready)
    else $error("result or new request right after a transfer");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_DONE |->
      out_tdata[33:2] == '0 && out_tdata[41:34] == '0)
    else $error("failed request reports data or position");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not idle after reset");

endmodule

bind positional_list_engine_core ple_port_check u_ple_port_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
